### src/jsu_pkg.sv
`timescale 1ns / 1ps

package jsu_pkg;

  // decoder phase, one-hot
  typedef enum logic [3:0] {
    PH_WAIT = 4'b0001,
    PH_BODY = 4'b0010,
    PH_ESC  = 4'b0100,
    PH_HEX  = 4'b1000
  } phase_t;

  // result kinds
  localparam logic [2:0] KIND_BYTE    = 3'd0;
  localparam logic [2:0] KIND_DONE    = 3'd1;
  localparam logic [2:0] KIND_NOQUOTE = 3'd2;
  localparam logic [2:0] KIND_BADESC  = 3'd3;
  localparam logic [2:0] KIND_TRUNC   = 3'd4;
  localparam logic [2:0] KIND_UNTERM  = 3'd5;

  // characters the decoder looks at
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  // control bytes produced by the simple escapes
  localparam logic [7:0] CTL_BS = 8'h08;
  localparam logic [7:0] CTL_FF = 8'h0C;
  localparam logic [7:0] CTL_LF = 8'h0A;
  localparam logic [7:0] CTL_CR = 8'h0D;
  localparam logic [7:0] CTL_HT = 8'h09;

  // utf-8 encoding constants
  localparam logic [7:0]  UTF_LEAD2 = 8'hC0;
  localparam logic [7:0]  UTF_LEAD3 = 8'hE0;
  localparam logic [7:0]  UTF_CONT  = 8'h80;
  localparam logic [5:0]  UTF_MASK  = 6'h3F;
  localparam logic [15:0] UTF_LIM1  = 16'h0080;
  localparam logic [15:0] UTF_LIM2  = 16'h0800;

  // one group of results caused by one input word
  typedef struct packed {
    logic [2:0] kind;
    logic [1:0] last_idx;   // index of the final result in the group
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
  } pkt_t;

  // hex digit decode: bit 4 flags a valid digit
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

  // code point to a group of one to three utf-8 bytes
  function automatic pkt_t utf8_enc(input logic [15:0] cp);
    pkt_t p;
    p = '0;
    p.kind = KIND_BYTE;
    if (cp < UTF_LIM1) begin
      p.last_idx = 2'd0;
      p.byte0    = cp[7:0];
    end else if (cp < UTF_LIM2) begin
      p.last_idx = 2'd1;
      p.byte0    = UTF_LEAD2 | {3'd0, cp[10:6]};
      p.byte1    = UTF_CONT | {2'd0, cp[5:0] & UTF_MASK};
    end else begin
      p.last_idx = 2'd2;
      p.byte0    = UTF_LEAD3 | {4'd0, cp[15:12]};
      p.byte1    = UTF_CONT | {2'd0, cp[11:6] & UTF_MASK};
      p.byte2    = UTF_CONT | {2'd0, cp[5:0] & UTF_MASK};
    end
    return p;
  endfunction

endpackage

### src/jsu_front.sv
`timescale 1ns / 1ps

module jsu_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    text_byte,
  input  logic          end_of_text,
  input  logic          q_full,
  output logic          push,
  output jsu_pkg::pkt_t push_pkt
);

  jsu_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]      hex_cnt_r, hex_cnt_nxt;
  logic [15:0]     cp_r, cp_nxt;
  logic            hex_stop_r, hex_stop_nxt;
  logic            emit;
  logic [4:0]      hd;
  logic [15:0]     cp_upd;
  logic            acc;

  assign in_ready = !q_full;
  assign acc      = in_valid && !q_full;
  assign push     = acc && emit;
  assign hd       = jsu_pkg::hex_digit(text_byte);

  // code point with this byte folded in
  always_comb begin
    cp_upd = cp_r;
    if (!hex_stop_r && hd[4]) begin
      cp_upd = {cp_r[11:0], hd[3:0]};
    end
  end

  // classify the word and build its result group
  always_comb begin
    phase_nxt    = phase_r;
    hex_cnt_nxt  = hex_cnt_r;
    cp_nxt       = cp_r;
    hex_stop_nxt = hex_stop_r;
    emit         = 1'b0;
    push_pkt     = '0;
    push_pkt.kind = jsu_pkg::KIND_BYTE;
    unique case (phase_r)
      jsu_pkg::PH_BODY: begin
        if (end_of_text) begin
          emit = 1'b1;
          push_pkt.kind = jsu_pkg::KIND_UNTERM;
          phase_nxt = jsu_pkg::PH_WAIT;
        end else if (text_byte == jsu_pkg::CH_QUOTE) begin
          emit = 1'b1;
          push_pkt.kind = jsu_pkg::KIND_DONE;
          phase_nxt = jsu_pkg::PH_WAIT;
        end else if (text_byte == jsu_pkg::CH_BSLASH) begin
          phase_nxt = jsu_pkg::PH_ESC;
        end else begin
          emit = 1'b1;
          push_pkt.byte0 = text_byte;
        end
      end
      jsu_pkg::PH_ESC: begin
        if (end_of_text) begin
          emit = 1'b1;
          push_pkt.kind = jsu_pkg::KIND_UNTERM;
          phase_nxt = jsu_pkg::PH_WAIT;
        end else begin
          phase_nxt = jsu_pkg::PH_BODY;
          emit = 1'b1;
          case (text_byte)
            jsu_pkg::CH_QUOTE:  push_pkt.byte0 = jsu_pkg::CH_QUOTE;
            jsu_pkg::CH_BSLASH: push_pkt.byte0 = jsu_pkg::CH_BSLASH;
            jsu_pkg::CH_SLASH:  push_pkt.byte0 = jsu_pkg::CH_SLASH;
            jsu_pkg::CH_B:      push_pkt.byte0 = jsu_pkg::CTL_BS;
            jsu_pkg::CH_F:      push_pkt.byte0 = jsu_pkg::CTL_FF;
            jsu_pkg::CH_N:      push_pkt.byte0 = jsu_pkg::CTL_LF;
            jsu_pkg::CH_R:      push_pkt.byte0 = jsu_pkg::CTL_CR;
            jsu_pkg::CH_T:      push_pkt.byte0 = jsu_pkg::CTL_HT;
            jsu_pkg::CH_U: begin
              emit = 1'b0;
              phase_nxt = jsu_pkg::PH_HEX;
              hex_cnt_nxt = 2'd0;
              cp_nxt = 16'd0;
              hex_stop_nxt = 1'b0;
            end
            default: begin
              push_pkt.kind = jsu_pkg::KIND_BADESC;
              phase_nxt = jsu_pkg::PH_WAIT;
            end
          endcase
        end
      end
      jsu_pkg::PH_HEX: begin
        if (end_of_text) begin
          emit = 1'b1;
          push_pkt.kind = jsu_pkg::KIND_TRUNC;
          phase_nxt = jsu_pkg::PH_WAIT;
        end else if (hex_cnt_r == 2'd3) begin
          // fourth byte: encode and go back to the body
          emit = 1'b1;
          push_pkt = jsu_pkg::utf8_enc(cp_upd);
          hex_cnt_nxt = 2'd0;
          cp_nxt = 16'd0;
          hex_stop_nxt = 1'b0;
          phase_nxt = jsu_pkg::PH_BODY;
        end else begin
          cp_nxt = cp_upd;
          hex_stop_nxt = hex_stop_r | !hd[4];
          hex_cnt_nxt = hex_cnt_r + 2'd1;
        end
      end
      default: begin
        // waiting for an opening quote
        if (!end_of_text && text_byte == jsu_pkg::CH_QUOTE) begin
          phase_nxt = jsu_pkg::PH_BODY;
        end else begin
          phase_nxt = jsu_pkg::PH_WAIT;
          emit = 1'b1;
          push_pkt.kind = jsu_pkg::KIND_NOQUOTE;
        end
      end
    endcase
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= jsu_pkg::PH_WAIT;
      hex_cnt_r  <= 2'd0;
      cp_r       <= 16'd0;
      hex_stop_r <= 1'b0;
    end else if (acc) begin
      phase_r    <= phase_nxt;
      hex_cnt_r  <= hex_cnt_nxt;
      cp_r       <= cp_nxt;
      hex_stop_r <= hex_stop_nxt;
    end
  end

endmodule

### src/jsu_queue.sv
`timescale 1ns / 1ps

module jsu_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jsu_pkg::pkt_t push_pkt,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output jsu_pkg::pkt_t head_pkt
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  jsu_pkg::pkt_t  mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full       = (cnt_r == FULL_CNT);
  assign head_valid = (cnt_r != '0);
  assign head_pkt   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_pkt;
    end
  end

endmodule

### src/jsu_back.sv
`timescale 1ns / 1ps

module jsu_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  jsu_pkg::pkt_t head_pkt,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic [2:0]    out_kind,
  output logic          out_last
);

  jsu_pkg::pkt_t pkt_r;
  logic          busy_r, busy_nxt;
  logic [1:0]    idx_r, idx_nxt;
  logic          ovalid_r, ovalid_nxt;
  logic [7:0]    obyte_r;
  logic [2:0]    okind_r;
  logic          olast_r;
  logic          adv;
  logic          fin;
  logic [7:0]    cur_byte;

  // one result per cycle, while the output register is empty or being read, from the working group into it
  assign adv = busy_r && (!ovalid_r || out_ready);
  assign fin = (idx_r == pkt_r.last_idx);
  assign pop = head_valid && (!busy_r || (adv && fin));

  always_comb begin
    case (idx_r)
      2'd0:    cur_byte = pkt_r.byte0;
      2'd1:    cur_byte = pkt_r.byte1;
      default: cur_byte = pkt_r.byte2;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = 2'd0;
    end else if (adv && fin) begin
      busy_nxt = 1'b0;
    end else if (adv) begin
      idx_nxt = idx_r + 2'd1;
    end
    ovalid_nxt = adv ? 1'b1 : (out_ready ? 1'b0 : ovalid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      idx_r    <= 2'd0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      idx_r    <= idx_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (pop) begin
      pkt_r <= head_pkt;
    end
    if (adv) begin
      obyte_r <= cur_byte;
      okind_r <= pkt_r.kind;
      olast_r <= fin;
    end
  end

  assign out_valid = ovalid_r;
  assign out_byte  = obyte_r;
  assign out_kind  = okind_r;
  assign out_last  = olast_r;

endmodule

### src/json_string_unescape_core.sv
`timescale 1ns / 1ps
// channel   dir  tdata              tuser              tlast
// in_       in   [7:0] text_byte    [0] end_of_text    -
// out_      out  [7:0] out_byte     [2:0] kind         last result of the input word
//
// one input word is taken per cycle while the result queue has room
// a word yields zero to three results; results leave one per cycle while out_tready is high,
// so a \u escape that encodes to three bytes holds the output for all three of its results
// a first result passes through the queue, the working group register and the output register
// rst_n is synchronous, active low, and returns the decoder to waiting for a quote
// either side may stall; the queue and the output register decouple them

module json_string_unescape_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] text_byte
  input  logic       in_tuser,   // [0] end_of_text
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [2:0] out_tuser,  // [2:0] kind
  output logic       out_tlast
);

  logic          push;
  jsu_pkg::pkt_t push_pkt;
  logic          q_full;
  logic          pop;
  logic          head_valid;
  jsu_pkg::pkt_t head_pkt;

  // front: accept and classify words
  jsu_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .text_byte   (in_tdata),
    .end_of_text (in_tuser),
    .q_full      (q_full),
    .push        (push),
    .push_pkt    (push_pkt)
  );

  // result groups in flight
  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_pkt   (push_pkt),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_pkt   (head_pkt)
  );

  // back: serialize groups onto the output
  jsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_pkt   (head_pkt),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (out_tdata),
    .out_kind   (out_tuser),
    .out_last   (out_tlast)
  );

endmodule
